/* design/vfc_pkg.sv */
// Shared types and helpers for the voxel face culler.
// Used by vfc_addr_gen and voxel_face_culler; depends on nothing.
`timescale 1ns / 1ps

package vfc_pkg;

	// Number of sides of a voxel, numbered in the order +y, -y, +x, -x, +z, -z.
	localparam int FACE_COUNT = 6;

	// Input action codes.
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// Which voxel the address unit points at.
	typedef enum logic [2:0] {
		SEL_CENTER,
		SEL_YP,
		SEL_YN,
		SEL_XP,
		SEL_XN
	} nb_sel_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_CHECK,
		ST_NB,
		ST_EMIT
	} state_t;

	// Lowest visible side in a mask of pending faces.
	function automatic logic [2:0] first_side(input logic [FACE_COUNT-1:0] mask);
		logic [2:0] side;
		side = 3'd0;
		for (int i = FACE_COUNT - 1; i >= 0; i--) begin
			if (mask[i]) begin
				side = 3'(i);
			end
		end
		return side;
	endfunction

endpackage

/* design/voxel_face_culler.sv */
// Voxel face culler top level: sequencer, solid bitmap and output register.
// Depends on vfc_pkg, vfc_addr_gen and vfc_ram.
`timescale 1ns / 1ps

// The solid bitmap lives in one RAM of CHUNK_WIDTH*CHUNK_HEIGHT rows, each row
// holding the CHUNK_WIDTH voxels of one (x, y) column along z. After reset the
// block runs a clearing pass over every row with item_stall high. A write
// transaction then does a row read, then a read-modify-write, and so does a
// query of an empty voxel; an item whose voxel lies outside the chunk ends after
// the lookup. A query of a solid voxel reads the center row and the four x/y
// neighbor rows one after another through the single RAM read port, then emits
// one face record per visible face; stalls on the face channel hold the emit
// state. Face records leave through an output register, so a new transaction is
// taken while the last record still waits for the consumer.
module voxel_face_culler #(
	parameter int CHUNK_WIDTH  = 16,
	parameter int CHUNK_HEIGHT = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic       action,
	input  logic [3:0] block_x,
	input  logic [7:0] block_y,
	input  logic [3:0] block_z,
	input  logic       solid,
	output logic       face_valid,
	input  logic       face_stall,
	output logic [3:0] face_x,
	output logic [7:0] face_y,
	output logic [3:0] face_z,
	output logic [2:0] face_side,
	output logic       last_face
);

	localparam int          ROWS   = CHUNK_WIDTH * CHUNK_HEIGHT;
	localparam int          ROW_AW = $clog2(ROWS);
	localparam logic [31:0] W32    = CHUNK_WIDTH;
	localparam int          FC     = vfc_pkg::FACE_COUNT;

	vfc_pkg::state_t  state_q, state_nx;
	vfc_pkg::nb_sel_t sel;

	logic [ROW_AW-1:0]      clr_cnt_q;
	logic                   act_q;
	logic [3:0]             x_q;
	logic [7:0]             y_q;
	logic [3:0]             z_q;
	logic                   solid_q;
	logic [2:0]             nb_cnt_q;
	logic                   nb_in_q;
	logic [FC-1:0]          vis_q;
	logic                   out_valid_q;
	logic [2:0]             side_q;
	logic                   last_q;
	logic [3:0]             face_x_q;
	logic [7:0]             face_y_q;
	logic [3:0]             face_z_q;

	logic                   in_chunk;
	logic [ROW_AW-1:0]      row;
	logic                   ram_we;
	logic [ROW_AW-1:0]      ram_waddr;
	logic [CHUNK_WIDTH-1:0] ram_wdata;
	logic [CHUNK_WIDTH-1:0] rdata;
	logic [CHUNK_WIDTH-1:0] rd_sh, rd_shp, rd_shm, bit_mask;
	logic                   rd_bit;
	logic                   zp_in;
	logic                   accept;
	logic                   out_free;
	logic                   out_load;
	logic [2:0]             next_side;
	logic [FC-1:0]          vis_rest;

	// Shared address unit, used for the center voxel and each neighbor row.
	vfc_addr_gen #(
		.CHUNK_WIDTH (CHUNK_WIDTH),
		.CHUNK_HEIGHT(CHUNK_HEIGHT)
	) u_addr (
		.x       (x_q),
		.y       (y_q),
		.z       (z_q),
		.sel     (sel),
		.in_chunk(in_chunk),
		.row     (row)
	);

	// Solid bitmap.
	vfc_ram #(
		.WIDTH(CHUNK_WIDTH),
		.DEPTH(ROWS)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(row),
		.rdata(rdata)
	);

	// Bits of the returned row: the voxel itself and its z neighbors.
	assign rd_sh    = rdata >> z_q;
	assign rd_shp   = rdata >> ({1'b0, z_q} + 5'd1);
	assign rd_shm   = rdata >> (z_q - 4'd1);
	assign rd_bit   = rd_sh[0];
	assign zp_in    = (32'({1'b0, z_q} + 5'd1) < W32);
	assign bit_mask = CHUNK_WIDTH'(1) << z_q;

	// Output register handshake and next pending face.
	assign out_free  = !out_valid_q || !face_stall;
	assign accept    = item_valid && !item_stall;
	assign next_side = vfc_pkg::first_side(vis_q);
	assign vis_rest  = vis_q & ~(FC'(1) << next_side);
	assign out_load  = (state_q == vfc_pkg::ST_EMIT) && out_free && (vis_q != '0);

	// Next-state logic of the sequencer.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			vfc_pkg::ST_CLEAR: begin
				if (clr_cnt_q == ROW_AW'(ROWS - 1)) begin
					state_nx = vfc_pkg::ST_IDLE;
				end
			end
			vfc_pkg::ST_IDLE: begin
				if (item_valid) begin
					state_nx = vfc_pkg::ST_LOOK;
				end
			end
			vfc_pkg::ST_LOOK: begin
				state_nx = in_chunk ? vfc_pkg::ST_CHECK : vfc_pkg::ST_IDLE;
			end
			vfc_pkg::ST_CHECK: begin
				if (act_q == vfc_pkg::ACT_QUERY && rd_bit) begin
					state_nx = vfc_pkg::ST_NB;
				end else begin
					state_nx = vfc_pkg::ST_IDLE;
				end
			end
			vfc_pkg::ST_NB: begin
				if (nb_cnt_q == 3'd4) begin
					state_nx = vfc_pkg::ST_EMIT;
				end
			end
			vfc_pkg::ST_EMIT: begin
				if (vis_q == '0 || (out_free && vis_rest == '0)) begin
					state_nx = vfc_pkg::ST_IDLE;
				end
			end
			default: state_nx = vfc_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs: handshake, address selection and bitmap writes.
	always_comb begin
		item_stall = 1'b1;
		sel        = vfc_pkg::SEL_CENTER;
		ram_we     = 1'b0;
		ram_waddr  = row;
		ram_wdata  = solid_q ? (rdata | bit_mask) : (rdata & ~bit_mask);
		unique case (state_q)
			vfc_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_cnt_q;
				ram_wdata = '0;
			end
			vfc_pkg::ST_IDLE: item_stall = 1'b0;
			vfc_pkg::ST_LOOK: sel = vfc_pkg::SEL_CENTER;
			vfc_pkg::ST_CHECK: begin
				ram_we = (act_q == vfc_pkg::ACT_WRITE);
			end
			vfc_pkg::ST_NB: begin
				unique case (nb_cnt_q)
					3'd0:    sel = vfc_pkg::SEL_YP;
					3'd1:    sel = vfc_pkg::SEL_YN;
					3'd2:    sel = vfc_pkg::SEL_XP;
					3'd3:    sel = vfc_pkg::SEL_XN;
					default: sel = vfc_pkg::SEL_CENTER;
				endcase
			end
			vfc_pkg::ST_EMIT: begin
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= vfc_pkg::ST_CLEAR;
			clr_cnt_q   <= '0;
			nb_cnt_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == vfc_pkg::ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + ROW_AW'(1);
			end
			if (state_q == vfc_pkg::ST_CHECK) begin
				nb_cnt_q <= '0;
			end else if (state_q == vfc_pkg::ST_NB) begin
				nb_cnt_q <= nb_cnt_q + 3'd1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!face_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Transaction fields, visibility mask and face record payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q   <= action;
			x_q     <= block_x;
			y_q     <= block_y;
			z_q     <= block_z;
			solid_q <= solid;
		end
		if (state_q == vfc_pkg::ST_CHECK) begin
			vis_q <= {!((z_q != 4'd0) && rd_shm[0]), !(zp_in && rd_shp[0]), 4'b0000};
		end
		if (state_q == vfc_pkg::ST_NB) begin
			nb_in_q <= in_chunk;
			if (nb_cnt_q != 3'd0) begin
				vis_q[nb_cnt_q - 3'd1] <= !(nb_in_q && rd_bit);
			end
		end
		if (out_load) begin
			face_x_q <= x_q;
			face_y_q <= y_q;
			face_z_q <= z_q;
			side_q   <= next_side;
			last_q   <= (vis_rest == '0);
			vis_q    <= vis_rest;
		end
	end

	// Face record outputs come straight from the output register.
	assign face_valid = out_valid_q;
	assign face_x     = face_x_q;
	assign face_y     = face_y_q;
	assign face_z     = face_z_q;
	assign face_side  = side_q;
	assign last_face  = last_q;

`ifndef SYNTHESIS
	// A new face record only ever comes out of the emit state.
	a_load_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> state_q == vfc_pkg::ST_EMIT)
		else $error("face record loaded outside the emit state");

	// Loading the final record of a query returns the sequencer to idle.
	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && vis_rest == '0 |=> state_q == vfc_pkg::ST_IDLE && last_face)
		else $error("sequencer did not finish after the last face");

	// The neighbor walk never runs past its four row reads.
	a_nb_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == vfc_pkg::ST_NB |-> nb_cnt_q <= 3'd4)
		else $error("neighbor counter out of range");

	// Coordinates of a pending record stay put while it waits.
	a_hold_coords: assert property (@(posedge clk) disable iff (!arst_n)
		face_valid && face_stall |=> $stable(face_x) && $stable(face_y) && $stable(face_z))
		else $error("face coordinates changed while stalled");
`endif

endmodule

/* design/vfc_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for the solid bitmap of the voxel face culler.
`timescale 1ns / 1ps

module vfc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* design/vfc_addr_gen.sv */
// Shared address unit: turns a voxel and a neighbor selection into a bitmap
// row address and an in-chunk flag. Depends on vfc_pkg.
`timescale 1ns / 1ps

module vfc_addr_gen #(
	parameter int CHUNK_WIDTH  = 16,
	parameter int CHUNK_HEIGHT = 256
) (
	input  logic [3:0]                                  x,
	input  logic [7:0]                                  y,
	input  logic [3:0]                                  z,
	input  vfc_pkg::nb_sel_t                            sel,
	output logic                                        in_chunk,
	output logic [$clog2(CHUNK_WIDTH*CHUNK_HEIGHT)-1:0] row
);

	localparam int          ROW_AW = $clog2(CHUNK_WIDTH * CHUNK_HEIGHT);
	localparam logic [31:0] W32    = CHUNK_WIDTH;
	localparam logic [31:0] H32    = CHUNK_HEIGHT;

	logic [4:0] nx;
	logic [8:0] ny;
	logic       no_wrap;

	// Neighbor coordinate; stepping below zero leaves the chunk.
	always_comb begin
		nx      = {1'b0, x};
		ny      = {1'b0, y};
		no_wrap = 1'b1;
		unique case (sel)
			vfc_pkg::SEL_CENTER: begin
			end
			vfc_pkg::SEL_YP: ny = {1'b0, y} + 9'd1;
			vfc_pkg::SEL_YN: begin
				ny      = {1'b0, y} - 9'd1;
				no_wrap = (y != 8'd0);
			end
			vfc_pkg::SEL_XP: nx = {1'b0, x} + 5'd1;
			vfc_pkg::SEL_XN: begin
				nx      = {1'b0, x} - 5'd1;
				no_wrap = (x != 4'd0);
			end
			default: begin
			end
		endcase
	end

	// Range check and row address (y * width + x); z selects a bit in the row.
	assign in_chunk = no_wrap && (32'(nx) < W32) && (32'(ny) < H32) && (32'(z) < W32);
	assign row      = ROW_AW'(32'(ny) * W32 + 32'(nx));

endmodule
